>>> rtl/pidc_pkg.sv
// Shared types, codes and fixed-point constants of the clamped PID regulator.
package pidc_pkg;

  // Q16.16 angle constants: pi and 2*pi rounded to nearest.
  localparam int unsigned PI_Q        = 205887;
  localparam int unsigned TWO_PI_Q    = 411775;
  localparam int unsigned WRAP_BIAS   = TWO_PI_Q - 1 - PI_Q;
  // Reciprocal of the Q16.16 2*pi constant scaled by 2^44; the estimate it gives is low by one at most.
  localparam int unsigned RECIP_SHIFT = 44;
  localparam logic [25:0] WRAP_RECIP  = 26'((64'd1 << RECIP_SHIFT) / 64'(TWO_PI_Q));

  localparam int unsigned CFG_W      = 31;
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned SUM_W      = 48;
  localparam int unsigned QUO_W      = 47;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN_P     = 4'd0,
    CFG_GAIN_I     = 4'd1,
    CFG_GAIN_D     = 4'd2,
    CFG_P_TERM_MAX = 4'd3,
    CFG_I_TERM_MAX = 4'd4,
    CFG_D_TERM_MAX = 4'd5,
    CFG_OUTPUT_MAX = 4'd6,
    CFG_ANGLE_WRAP = 4'd7
  } cfg_idx_e;

  typedef enum logic {
    OP_STEP  = 1'b0,
    OP_CLEAR = 1'b1
  } op_e;

  // One classified transaction handed from the front end to the back end.
  typedef struct packed {
    logic               clear;
    logic signed [31:0] err;
  } item_t;

  // Gains and limits seen by the back end.
  typedef struct packed {
    logic [CFG_W-1:0] gain_p;
    logic [CFG_W-1:0] gain_i;
    logic [CFG_W-1:0] gain_d;
    logic [CFG_W-1:0] p_term_max;
    logic [CFG_W-1:0] i_term_max;
    logic [CFG_W-1:0] d_term_max;
    logic [CFG_W-1:0] output_max;
  } gains_t;

endpackage

>>> rtl/pidc_bound_div.sv
// Bit-serial divider forming the integral sum bound (i_term_max << 16) / gain_i.
module pidc_bound_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [pidc_pkg::CFG_W-1:0]     divisor_i,
  input  logic [pidc_pkg::CFG_W-1:0]     i_term_max_i,
  output logic                           busy_o,
  output logic [pidc_pkg::SUM_W-1:0]     bound_o
);

  localparam int unsigned QW   = pidc_pkg::QUO_W;
  localparam int unsigned CNTW = $clog2(QW + 1);

  logic                           busy_q, busy_d;
  logic [CNTW-1:0]                cnt_q, cnt_d;
  logic [QW-1:0]                  num_q, num_d;
  logic [pidc_pkg::DATA_W-1:0]    rem_q, rem_d;
  logic [pidc_pkg::SUM_W-1:0]     bound_q, bound_d;
  logic [pidc_pkg::DATA_W-1:0]    rem_sh;
  logic                           ge;

  assign rem_sh = {rem_q[pidc_pkg::DATA_W-2:0], num_q[QW-1]};
  assign ge     = rem_sh >= {1'b0, divisor_i};

  always_comb begin
    busy_d  = busy_q;
    cnt_d   = cnt_q;
    num_d   = num_q;
    rem_d   = rem_q;
    bound_d = bound_q;
    if (start_i) begin
      // restart on every write: the newest register values win
      num_d = {i_term_max_i, 16'd0};
      rem_d = '0;
      cnt_d = CNTW'(QW);
      if (divisor_i == '0) begin
        busy_d  = 1'b0;
        bound_d = '0;
      end else begin
        busy_d = 1'b1;
      end
    end else if (busy_q) begin
      rem_d = ge ? (rem_sh - {1'b0, divisor_i}) : rem_sh;
      num_d = {num_q[QW-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNTW'(1)) begin
        busy_d  = 1'b0;
        bound_d = {1'b0, num_d};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      cnt_q   <= '0;
      bound_q <= '0;
    end else begin
      busy_q  <= busy_d;
      cnt_q   <= cnt_d;
      bound_q <= bound_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
  end

  assign busy_o  = busy_q;
  assign bound_o = bound_q;

endmodule

>>> rtl/pidc_front.sv
// Front end: accept transactions, form the saturated error and wrap it in angle mode.
module pidc_front #(
  parameter int unsigned DEPTH = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         operation_i,
  input  logic signed [31:0]           setpoint_i,
  input  logic signed [31:0]           measured_i,
  input  logic                         angle_wrap_i,
  input  logic                         hold_i,
  input  logic [$clog2(DEPTH+1)-1:0]   queue_count_i,
  output logic                         push_o,
  output pidc_pkg::item_t              push_item_o
);

  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic               accept;
  logic signed [32:0] diff;
  logic signed [31:0] err_sat;
  logic               pos_wrap, neg_wrap;
  logic [32:0]        mag;
  logic [31:0]        t_val;

  logic               v1_q, v2_q, v3_q;
  logic               clr1_q, clr2_q, clr3_q;
  logic               pos1_q, pos2_q, pos3_q;
  logic               neg1_q, neg2_q, neg3_q;
  logic signed [31:0] err1_q, err2_q, err3_q;
  logic [31:0]        t1_q;
  logic [57:0]        qprod;
  logic [13:0]        q2_q;
  logic [32:0]        m3_q;
  logic signed [33:0] e_ext, e_raw, e_fix;
  logic [CW:0]        in_flight;

  // credit: every transaction in the pipe already owns a queue slot
  assign in_flight  = (CW+1)'(queue_count_i) + (CW+1)'(v1_q) + (CW+1)'(v2_q) + (CW+1)'(v3_q);
  assign in_stall_o = hold_i || (in_flight >= (CW+1)'(DEPTH));
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    diff = {setpoint_i[31], setpoint_i} - {measured_i[31], measured_i};
    // saturate symmetrically to +/- (2^31 - 1): the most negative code never appears
    if (diff > 33'sh0_7FFF_FFFF) begin
      err_sat = 32'sh7FFF_FFFF;
    end else if (diff < -33'sh0_7FFF_FFFF) begin
      err_sat = 32'sh8000_0001;
    end else begin
      err_sat = diff[31:0];
    end
    pos_wrap = angle_wrap_i && (err_sat > $signed(32'(pidc_pkg::PI_Q)));
    neg_wrap = angle_wrap_i && (err_sat < -$signed(32'(pidc_pkg::PI_Q)));
    mag      = neg_wrap ? (33'd0 - {err_sat[31], err_sat}) : {err_sat[31], err_sat};
    t_val    = mag[31:0] + 32'(pidc_pkg::WRAP_BIAS);
  end

  assign qprod = 58'(t1_q) * 58'(pidc_pkg::WRAP_RECIP);

  always_comb begin
    e_ext = 34'(err3_q);
    e_raw = neg3_q ? (e_ext + $signed({1'b0, m3_q})) : (e_ext - $signed({1'b0, m3_q}));
    e_fix = e_raw;
    // estimate may be one short: apply one more turn
    if (pos3_q && (e_raw > $signed(34'(pidc_pkg::PI_Q)))) begin
      e_fix = e_raw - $signed(34'(pidc_pkg::TWO_PI_Q));
    end else if (neg3_q && (e_raw < -$signed(34'(pidc_pkg::PI_Q)))) begin
      e_fix = e_raw + $signed(34'(pidc_pkg::TWO_PI_Q));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= accept;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    clr1_q <= (pidc_pkg::op_e'(operation_i) == pidc_pkg::OP_CLEAR);
    pos1_q <= pos_wrap;
    neg1_q <= neg_wrap;
    err1_q <= err_sat;
    t1_q   <= t_val;
    clr2_q <= clr1_q;
    pos2_q <= pos1_q;
    neg2_q <= neg1_q;
    err2_q <= err1_q;
    q2_q   <= qprod[57:pidc_pkg::RECIP_SHIFT];
    clr3_q <= clr2_q;
    pos3_q <= pos2_q;
    neg3_q <= neg2_q;
    err3_q <= err2_q;
    m3_q   <= 33'(q2_q) * 33'(pidc_pkg::TWO_PI_Q);
  end

  assign push_o            = v3_q;
  assign push_item_o.clear = clr3_q;
  assign push_item_o.err   = (pos3_q || neg3_q) ? e_fix[31:0] : err3_q;

endmodule

>>> rtl/pidc_queue.sv
// Small FIFO of classified transactions between front and back end.
module pidc_queue #(
  parameter int unsigned DEPTH = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  pidc_pkg::item_t              push_item_i,
  input  logic                         pop_i,
  output logic                         valid_o,
  output pidc_pkg::item_t              head_o,
  output logic [$clog2(DEPTH+1)-1:0]   count_o
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  pidc_pkg::item_t mem_q [DEPTH];
  logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]   count_q, count_d;

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign count_o = count_q;

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |-> (count_q < CW'(DEPTH)))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> (count_q != '0))
    else $error("queue read while empty");

endmodule

>>> rtl/pidc_back.sv
// Back end: integrate, form and clamp the three terms, sum and hold the drive.
module pidc_back (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  pidc_pkg::gains_t                   gains_i,
  input  logic [pidc_pkg::SUM_W-1:0]         sum_bound_i,
  input  logic                               head_valid_i,
  input  pidc_pkg::item_t                    head_i,
  output logic                               pop_o,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [31:0]                 drive_o
);

  localparam int unsigned SW = pidc_pkg::SUM_W;

  function automatic logic signed [31:0] clamp_sym(input logic signed [79:0] v,
                                                   input logic [30:0] lim);
    logic signed [79:0] hi;
    logic signed [79:0] lo;
    hi = $signed({49'd0, lim});
    lo = -hi;
    if (v > hi) begin
      return hi[31:0];
    end else if (v < lo) begin
      return lo[31:0];
    end
    return v[31:0];
  endfunction

  logic                  adv;
  logic signed [SW-1:0]  esum_q, esum_d;
  logic signed [31:0]    last_q, last_d;
  logic signed [SW:0]    acc, bnd;

  logic                  va_q, vb_q, vc_q, out_valid_q;
  logic                  clra_q, clrb_q, clrc_q;
  logic signed [31:0]    erra_q;
  logic signed [SW-1:0]  suma_q;
  logic signed [32:0]    diffa_q;
  logic signed [63:0]    pprod_q;
  logic signed [56:0]    ilo_q;
  logic signed [55:0]    ihi_q;
  logic signed [64:0]    dprod_q;
  logic signed [79:0]    p_wide, i_wide, d_wide, i_hi_ext, i_lo_ext;
  logic signed [31:0]    pt_q, it_q, dt_q, drive_q;
  logic signed [33:0]    total;
  logic signed [79:0]    total_ext;

  // advance the whole back pipe unless a finished drive is being held
  assign adv   = !(out_valid_q && out_stall_i);
  assign pop_o = adv && head_valid_i;

  // running state: one transaction a cycle in queue order while the back pipe advances
  always_comb begin
    bnd    = $signed({1'b0, sum_bound_i});
    acc    = (SW+1)'(esum_q) + (SW+1)'(head_i.err);
    esum_d = esum_q;
    last_d = last_q;
    if (pop_o) begin
      if (head_i.clear) begin
        esum_d = '0;
        last_d = '0;
      end else begin
        last_d = head_i.err;
        if (gains_i.gain_i == '0) begin
          esum_d = '0;
        end else if (acc > bnd) begin
          esum_d = bnd[SW-1:0];
        end else if (acc < -bnd) begin
          esum_d = SW'(-bnd);
        end else begin
          esum_d = acc[SW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esum_q      <= '0;
      last_q      <= '0;
      va_q        <= 1'b0;
      vb_q        <= 1'b0;
      vc_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      esum_q <= esum_d;
      last_q <= last_d;
      if (adv) begin
        va_q        <= pop_o;
        vb_q        <= va_q;
        vc_q        <= vb_q;
        out_valid_q <= vc_q;
      end
    end
  end

  always_comb begin
    i_hi_ext = ihi_q;
    i_lo_ext = ilo_q;
    p_wide   = pprod_q >>> 16;
    i_wide   = ((i_hi_ext <<< 24) + i_lo_ext) >>> 16;
    d_wide   = dprod_q >>> 16;
    total    = 34'(pt_q) + 34'(it_q) + 34'(dt_q);
    total_ext = total;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      // stage A: state update result and error difference
      clra_q  <= head_i.clear;
      erra_q  <= head_i.err;
      suma_q  <= esum_d;
      diffa_q <= 33'(head_i.err) - 33'(last_q);
      // stage B: products; the upper half of the sum carries its sign
      clrb_q  <= clra_q;
      pprod_q <= erra_q * $signed({1'b0, gains_i.gain_p});
      ilo_q   <= $signed({1'b0, suma_q[23:0]}) * $signed({1'b0, gains_i.gain_i});
      ihi_q   <= $signed(suma_q[SW-1:24]) * $signed({1'b0, gains_i.gain_i});
      dprod_q <= diffa_q * $signed({1'b0, gains_i.gain_d});
      // stage C: floor-scaled terms, each clamped
      clrc_q  <= clrb_q;
      pt_q    <= clamp_sym(p_wide, gains_i.p_term_max);
      it_q    <= clamp_sym(i_wide, gains_i.i_term_max);
      dt_q    <= clamp_sym(d_wide, gains_i.d_term_max);
      // output register
      drive_q <= clrc_q ? 32'sd0 : clamp_sym(total_ext, gains_i.output_max);
    end
  end

  assign out_valid_o = out_valid_q;
  assign drive_o     = drive_q;

  a_clear_zeroes_history: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && head_i.clear) |=> (esum_q == '0 && last_q == '0))
    else $error("clear left history behind");

  a_drive_in_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (drive_q <= $signed({1'b0, gains_i.output_max})
                     && drive_q >= -$signed({1'b0, gains_i.output_max})))
    else $error("drive beyond output limit");

endmodule

>>> rtl/pid_regulator_clamped_top.sv
// Top level of the clamped positional PID regulator: registers, bound divider, front, queue, back.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+-------------------------------------
//  in      | sink      | in_valid_i / in_stall_o   | operation_i, setpoint_i, measured_i
//  out     | source    | out_valid_o / out_stall_i | drive_o
//  cfg     | sink      | cfg_we_i                  | cfg_idx_i, cfg_data_i
//
//  One transaction per cycle sustained unless a stall holds it; from input accept to drive valid a
//  transaction passes three front stages for the error and its angle wrap, the queue, four back stages.
//  The integral and difference history update in a single back stage, so consecutive
//  transactions chain through it each cycle while the back end advances.
//  After a write to a listed register, input is stalled while the bit-serial divider forms the sum
//  bound; the divider runs only when gain_i is nonzero. Reset needs no clearing pass.
//  A stall on the output holds the back end; the queue keeps taking front-end traffic until
//  its credit is used up, then in_stall_o rises.
module pid_regulator_clamped_top #(
  parameter int unsigned QUEUE_DEPTH = 8
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // input transaction
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic                                 operation_i,
  input  logic signed [31:0]                   setpoint_i,
  input  logic signed [31:0]                   measured_i,
  // result transaction
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [31:0]                   drive_o,
  // register writes
  input  logic                                 cfg_we_i,
  input  logic [pidc_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [pidc_pkg::CFG_W-1:0]           cfg_data_i
);

  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  pidc_pkg::gains_t               gains_q;
  logic                           angle_wrap_q;
  logic                           cfg_hit;
  logic                           start_q;
  logic                           div_busy;
  logic                           hold;
  logic [pidc_pkg::SUM_W-1:0]     sum_bound;

  logic                           push;
  pidc_pkg::item_t                push_item;
  logic                           pop;
  logic                           head_valid;
  pidc_pkg::item_t                head;
  logic [CW-1:0]                  queue_count;

  // Register file: writes beyond the list are dropped and start no recompute.
  always_comb begin
    case (cfg_idx_i)
      pidc_pkg::CFG_GAIN_P,
      pidc_pkg::CFG_GAIN_I,
      pidc_pkg::CFG_GAIN_D,
      pidc_pkg::CFG_P_TERM_MAX,
      pidc_pkg::CFG_I_TERM_MAX,
      pidc_pkg::CFG_D_TERM_MAX,
      pidc_pkg::CFG_OUTPUT_MAX,
      pidc_pkg::CFG_ANGLE_WRAP: cfg_hit = cfg_we_i;
      default:                  cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gains_q      <= '0;
      angle_wrap_q <= 1'b0;
      start_q      <= 1'b0;
    end else begin
      // kick the divider in the cycle after the write so it sees the new value
      start_q <= cfg_hit;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          pidc_pkg::CFG_GAIN_P:     gains_q.gain_p     <= cfg_data_i;
          pidc_pkg::CFG_GAIN_I:     gains_q.gain_i     <= cfg_data_i;
          pidc_pkg::CFG_GAIN_D:     gains_q.gain_d     <= cfg_data_i;
          pidc_pkg::CFG_P_TERM_MAX: gains_q.p_term_max <= cfg_data_i;
          pidc_pkg::CFG_I_TERM_MAX: gains_q.i_term_max <= cfg_data_i;
          pidc_pkg::CFG_D_TERM_MAX: gains_q.d_term_max <= cfg_data_i;
          pidc_pkg::CFG_OUTPUT_MAX: gains_q.output_max <= cfg_data_i;
          pidc_pkg::CFG_ANGLE_WRAP: angle_wrap_q       <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

  // Hold input while a bound recompute is pending or running.
  assign hold = start_q || div_busy;

  pidc_bound_div u_bound_div (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_q),
    .divisor_i    (gains_q.gain_i),
    .i_term_max_i (gains_q.i_term_max),
    .busy_o       (div_busy),
    .bound_o      (sum_bound)
  );

  pidc_front #(
    .DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .operation_i   (operation_i),
    .setpoint_i    (setpoint_i),
    .measured_i    (measured_i),
    .angle_wrap_i  (angle_wrap_q),
    .hold_i        (hold),
    .queue_count_i (queue_count),
    .push_o        (push),
    .push_item_o   (push_item)
  );

  pidc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .pop_i       (pop),
    .valid_o     (head_valid),
    .head_o      (head),
    .count_o     (queue_count)
  );

  pidc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .gains_i      (gains_q),
    .sum_bound_i  (sum_bound),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .drive_o      (drive_o)
  );

endmodule
